// ===== src/sy_pkg.sv =====
`default_nettype none

package sy_pkg;

    localparam int DEF_STACK_DEPTH = 16;

    // Request types
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Symbol codes
    localparam logic [2:0] SYM_PLUS  = 3'd0;
    localparam logic [2:0] SYM_MINUS = 3'd1;
    localparam logic [2:0] SYM_TIMES = 3'd2;
    localparam logic [2:0] SYM_DIV   = 3'd3;
    localparam logic [2:0] SYM_OPEN  = 3'd4;
    localparam logic [2:0] SYM_CLOSE = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNMATCHED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    function automatic logic [1:0] priority_of(input logic [2:0] sym);
        logic [1:0] pr;
        case (sym)
            SYM_PLUS, SYM_MINUS: pr = 2'd1;
            SYM_TIMES, SYM_DIV:  pr = 2'd2;
            default:             pr = 2'd0;
        endcase
        return pr;
    endfunction

endpackage

`default_nettype wire

// ===== src/sy_ifs.sv =====
`default_nettype none

interface sy_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [2:0] symbol;

    modport source (output valid, output req_type, output symbol, input ready);
    modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

interface sy_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] emitted_op;
    logic       has_op;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output emitted_op, output has_op, output last,
                    output status, input ready);
    modport sink   (input valid, input emitted_op, input has_op, input last,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== src/sy_stack_mem.sv =====
`default_nettype none

module sy_stack_mem
    import sy_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int AW          = $clog2(STACK_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [2:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [2:0]         o_rdata
);

    logic [2:0] r_mem [STACK_DEPTH];
    logic [2:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/shunting_yard_operator_stack.sv =====
// Sequence: a request is taken in the idle state, then each stacked entry it examines
// takes a step of the read state (one read of the stack memory each), then the finish
// state delivers the last item. A new request is taken once back in idle, even while
// that item waits; one item per cycle while popping. A stalled result holds the block.
// Reset (synchronous, active low) empties the stack and the output register; the
// stack memory itself is not cleared, since only entries below the count are read.
`default_nettype none

module shunting_yard_operator_stack
    import sy_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sy_req_if.sink      i_req,
    sy_res_if.source    o_res
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_FIN} t_state;

    t_state        r_state;
    logic [1:0]    r_req;
    logic [2:0]    r_sym;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_opens;
    logic          r_found;
    logic          r_pend_v;
    logic [2:0]    r_pend_op;
    logic          r_out_v;
    logic [2:0]    r_out_op;
    logic          r_out_has;
    logic          r_out_last;
    logic [1:0]    r_out_st;

    logic          accept;
    logic          out_free;
    logic          out_load;
    logic          needs_read;
    logic [2:0]    top;
    logic          do_pop;
    logic          do_discard;
    logic          more;
    logic          is_stackable;
    logic          full;
    logic [1:0]    fin_status;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [2:0]    mem_rdata;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_v || o_res.ready;
    assign top      = mem_rdata;
    assign cnt_m1   = r_cnt - CW'(1);
    assign cnt_m2   = r_cnt - CW'(2);
    assign full     = (r_cnt == CW'(STACK_DEPTH));

    assign is_stackable = (r_req == REQ_PUSH) && (r_sym <= SYM_OPEN);

    always_comb begin
        needs_read = 1'b0;
        if (r_cnt != '0) begin
            case (i_req.req_type)
                REQ_POP:  needs_read = 1'b1;
                REQ_PUSH: needs_read = (i_req.symbol <= SYM_DIV) ||
                                       (i_req.symbol == SYM_CLOSE);
                default:  needs_read = 1'b0;
            endcase
        end
    end

    // Decision on the entry now at the top of the stack.
    always_comb begin
        do_pop     = 1'b0;
        do_discard = 1'b0;
        if (r_req == REQ_POP) begin
            do_pop = 1'b1;
        end else if (r_sym == SYM_CLOSE) begin
            if (r_found && top == SYM_OPEN) begin
                do_discard = 1'b1;
            end else begin
                do_pop = 1'b1;
            end
        end else begin
            do_pop = (priority_of(top) >= priority_of(r_sym));
        end
    end

    // A pop request stops after one entry; other pops go on while entries remain.
    assign more = do_pop && (r_req != REQ_POP) && (r_cnt > CW'(1));

    assign out_load = out_free &&
                      ((r_state == S_FIN) || (r_state == S_READ && do_pop && r_pend_v));

    always_comb begin
        if (is_stackable && full) begin
            fin_status = ST_OVERFLOW;
        end else if (r_req == REQ_PUSH && r_sym == SYM_CLOSE && !r_found) begin
            fin_status = ST_UNMATCHED;
        end else begin
            fin_status = ST_OK;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = cnt_m1[AW-1:0];
        if (r_state == S_IDLE) begin
            mem_re = accept && needs_read;
        end else if (r_state == S_READ) begin
            mem_re    = out_free && more;
            mem_raddr = cnt_m2[AW-1:0];
        end
    end

    assign mem_we = (r_state == S_FIN) && out_free && is_stackable && !full;

    sy_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_sym),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_opens  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= i_req.req_type;
                        r_sym    <= i_req.symbol;
                        r_found  <= (r_opens != '0);
                        r_pend_v <= 1'b0;
                        if (i_req.req_type == REQ_CLEAR) begin
                            r_cnt   <= '0;
                            r_opens <= '0;
                        end
                        r_state <= needs_read ? S_READ : S_FIN;
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        if (do_pop) begin
                            // The previous popped entry is now known not to be last.
                            if (r_pend_v) begin
                                r_out_op   <= r_pend_op;
                                r_out_has  <= 1'b1;
                                r_out_last <= 1'b0;
                                r_out_st   <= ST_OK;
                            end
                            r_pend_v  <= 1'b1;
                            r_pend_op <= top;
                            r_cnt     <= cnt_m1;
                            if (top == SYM_OPEN) begin
                                r_opens <= r_opens - CW'(1);
                            end
                            r_state <= more ? S_READ : S_FIN;
                        end else if (do_discard) begin
                            r_cnt   <= cnt_m1;
                            r_opens <= r_opens - CW'(1);
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_op   <= r_pend_v ? r_pend_op : SYM_PLUS;
                        r_out_has  <= r_pend_v;
                        r_out_last <= 1'b1;
                        r_out_st   <= fin_status;
                        r_pend_v   <= 1'b0;
                        if (is_stackable && !full) begin
                            r_cnt <= r_cnt + CW'(1);
                            if (r_sym == SYM_OPEN) begin
                                r_opens <= r_opens + CW'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_v;
    assign o_res.emitted_op = r_out_op;
    assign o_res.has_op     = r_out_has;
    assign o_res.last       = r_out_last;
    assign o_res.status     = r_out_st;

endmodule

`default_nettype wire

// ===== src/sy_checker.sv =====
`default_nettype none

module sy_checker
    import sy_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_out_op,
    input wire logic       i_out_has,
    input wire logic       i_out_last,
    input wire logic [1:0] i_out_status
);

    logic [1:0] r_open;
    logic       in_acc;
    logic       out_done;

    assign in_acc   = i_in_valid && i_in_ready;
    assign out_done = i_out_valid && i_out_ready && i_out_last;

    // A request is open from its acceptance until its last item is taken. A new
    // request may be taken while the last item of the previous one still waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {1'b0, in_acc} - {1'b0, out_done};
        end
    end

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_open <= 2'd1))
        else $error("request accepted while two are still open");

    a_no_stray_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_open != 2'd0))
        else $error("result item without an open request");

    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_has) |-> (i_out_op == SYM_PLUS && i_out_last))
        else $error("empty item must be the only, final one with a zero operator");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != ST_OK) |-> i_out_last)
        else $error("error status on an item that is not last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_op) && $stable(i_out_has) &&
             $stable(i_out_last) && $stable(i_out_status)))
        else $error("stalled result item changed");

endmodule

bind shunting_yard_operator_stack sy_checker u_sy_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_op     (o_res.emitted_op),
    .i_out_has    (o_res.has_op),
    .i_out_last   (o_res.last),
    .i_out_status (o_res.status)
);

`default_nettype wire
